// ===== hw/rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and codes for the min-heap priority queue
// Beat structs for both channels, opcodes and status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int VAL_W = 32;
    localparam int OCC_W = 7;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [VAL_W-1:0] push_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
        logic [OCC_W-1:0]        occupancy;
    } t_out_beat;

endpackage

// ===== hw/rtl/mhpq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_store: heap entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mhpq_store #(
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(DEPTH)-1:0]             i_waddr,
    input  logic [mhpq_pkg::VAL_W-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]             i_raddr,
    output logic [mhpq_pkg::VAL_W-1:0]           o_rdata
);
    import mhpq_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/min_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top: binary min-heap priority queue
// Push, pop-minimum and peek-minimum on signed 32-bit values, one status
// beat returned per request.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//
// A push compares the value with each parent in turn until it stops or reaches
// the root. A pop reads the root and the last entry, then for each level
// descended reads the two children, compares each child in turn and makes a
// move. A peek reads the root; a refused request or a no-op goes straight to
// the result beat. The sequencing is set by the single read port of the entry
// memory and the one shared signed comparator, both used once per step of the sequencer.
// Reset is synchronous and active low; it empties the queue at once, and the
// memory contents are not cleared since entries are only used once written.
// A new request is taken only while the sequencer is idle; the result beat
// sits in an output register, so a stalled output does not block acceptance
// of the next request, only the completion of that request.
//
module min_heap_priority_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mhpq_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mhpq_pkg::t_out_beat  o_out_data
);
    import mhpq_pkg::*;

    // Address width, count width (holds DEPTH itself), and child index width.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMPR,
        S_DN_MOVE,
        S_PK_RD,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_pos;
    logic [VAL_W-1:0]   r_val;
    logic [VAL_W-1:0]   r_bval;
    logic [ADDR_W-1:0]  r_bidx;
    logic               r_moved;
    logic [VAL_W-1:0]   r_res;
    logic [1:0]         r_st;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               in_acc;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]  parent;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic [IDX_W-1:0]   cnt_ext;
    logic               left_in;
    logic               right_in;
    logic [VAL_W-1:0]   cmp_a;
    logic [VAL_W-1:0]   cmp_b;
    logic               less;
    logic               out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !(r_out_valid && i_out_stall);

    // Heap index arithmetic: parent of the hole, and its two children.
    assign parent    = (r_pos - ADDR_W'(1)) >> 1;
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + IDX_W'(1);
    assign cnt_ext   = IDX_W'(r_cnt);
    assign left_in   = (left_idx < cnt_ext);
    assign right_in  = (right_idx < cnt_ext);

    // The one signed comparator, shared by every step that orders values.
    always_comb begin
        cmp_a = ram_rdata;
        cmp_b = r_val;
        case (r_state)
            S_UP_CMP:  begin
                cmp_a = r_val;
                cmp_b = ram_rdata;
            end
            S_DN_CMPR: begin
                cmp_a = ram_rdata;
                cmp_b = r_bval;
            end
            default:   begin
                cmp_a = ram_rdata;
                cmp_b = r_val;
            end
        endcase
    end

    assign less = ($signed(cmp_a) < $signed(cmp_b));

    // Memory access. The moving value is held in r_val and only written once
    // its final slot is known; entries it passes are shifted into the hole.
    always_comb begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        unique case (r_state)
            S_IDLE:    ram_raddr = '0;
            S_UP_CHK:  begin
                ram_raddr = parent;
                ram_we    = (r_pos == '0);
            end
            S_UP_CMP:  begin
                ram_we    = 1'b1;
                ram_wdata = less ? ram_rdata : r_val;
            end
            S_DN_ROOT: ram_raddr = r_cnt[ADDR_W-1:0];
            S_DN_L:    begin
                ram_raddr = left_idx[ADDR_W-1:0];
                ram_we    = !left_in;
            end
            S_DN_R:    ram_raddr = right_idx[ADDR_W-1:0];
            S_DN_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = r_moved ? r_bval : r_val;
            end
            S_DN_LAST, S_DN_CMPR, S_PK_RD, S_FIN: ram_raddr = '0;
            default:   ram_raddr = '0;
        endcase
    end

    mhpq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A beat taken downstream frees the register unless a new one loads.
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res <= '0;
                        case (i_in_data.opcode)
                            OP_PUSH: begin
                                if (r_cnt == CNT_W'(DEPTH)) begin
                                    r_st    <= ST_FULL;
                                    r_state <= S_FIN;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_val   <= i_in_data.push_value;
                                    r_pos   <= r_cnt[ADDR_W-1:0];
                                    r_cnt   <= r_cnt + CNT_W'(1);
                                    r_state <= S_UP_CHK;
                                end
                            end
                            OP_POP: begin
                                if (r_cnt == '0) begin
                                    r_st    <= ST_EMPTY;
                                    r_state <= S_FIN;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_cnt   <= r_cnt - CNT_W'(1);
                                    r_state <= S_DN_ROOT;
                                end
                            end
                            OP_PEEK: begin
                                if (r_cnt == '0) begin
                                    r_st    <= ST_EMPTY;
                                    r_state <= S_FIN;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_state <= S_PK_RD;
                                end
                            end
                            default: begin
                                r_st    <= ST_OK;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_UP_CHK: begin
                    r_state <= (r_pos == '0) ? S_FIN : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (less) begin
                        r_pos   <= parent;
                        r_state <= S_UP_CHK;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DN_ROOT: begin
                    r_res   <= ram_rdata;
                    r_state <= (r_cnt == '0) ? S_FIN : S_DN_LAST;
                end
                S_DN_LAST: begin
                    r_val   <= ram_rdata;
                    r_pos   <= '0;
                    r_state <= S_DN_L;
                end
                S_DN_L: begin
                    r_state <= left_in ? S_DN_R : S_FIN;
                end
                S_DN_R: begin
                    // Strict compare keeps the moving value on a tie with the left child.
                    r_moved <= less;
                    r_bval  <= less ? ram_rdata : r_val;
                    r_bidx  <= left_idx[ADDR_W-1:0];
                    r_state <= right_in ? S_DN_CMPR : S_DN_MOVE;
                end
                S_DN_CMPR: begin
                    if (less) begin
                        r_moved <= 1'b1;
                        r_bval  <= ram_rdata;
                        r_bidx  <= right_idx[ADDR_W-1:0];
                    end
                    r_state <= S_DN_MOVE;
                end
                S_DN_MOVE: begin
                    if (r_moved) begin
                        r_pos   <= r_bidx;
                        r_state <= S_DN_L;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_PK_RD: begin
                    r_res   <= ram_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.result_value <= r_res;
                        r_out.status       <= r_st;
                        r_out.occupancy    <= OCC_W'(r_cnt);
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The entry count never passes the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Every memory write lands inside the live part of the heap.
    a_write_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CNT_W'(ram_waddr) < r_cnt))
        else $error("heap write outside live entries");

    // A push while full leaves the heap untouched.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.opcode == OP_PUSH && r_cnt == CNT_W'(DEPTH))
        |=> (r_cnt == CNT_W'(DEPTH) && r_st == ST_FULL))
        else $error("push while full changed the heap");

    // A pop from a non-empty heap removes exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.opcode == OP_POP && r_cnt != '0)
        |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    // An empty status always carries a zero value.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> (r_out.result_value == '0))
        else $error("empty status with nonzero value");

endmodule
